// ===== rtl/core/tkcs_pkg.sv =====
// shared types, constants and state encoding for the top-k count selector
package tkcs_pkg;

   localparam int KEEP_DEPTH_DEF = 1024;
   localparam int ID_BITS_DEF    = 16;
   localparam int COUNT_BITS_DEF = 32;
   localparam int STAMP_BITS     = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TAKE   = 1'b1;

   typedef struct packed {
      logic        op;
      logic [15:0] origin_id;
      logic [15:0] dest_id;
      logic [31:0] trip_count;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [15:0] out_origin_id;
      logic [15:0] out_dest_id;
      logic [31:0] out_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_MOVE,
      ST_REPLACE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/top_k_count_selector.sv =====
// top-k count selector: linear-scan keeper of the records with the largest counts
// insert when not full: written on acceptance; full insert: scan, then replace the least
// record if the new count is larger; take: scan, read last record, move it into the taken
// slot, then give the result beat; empty take: an all-zero result beat
// one request at a time; the scan reads one entry per cycle through a single compare unit
// reset: synchronous, active high; clears record count, arrival stamp and handshake state
module top_k_count_selector #(
   parameter int KEEP_DEPTH = tkcs_pkg::KEEP_DEPTH_DEF,
   parameter int ID_BITS    = tkcs_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = tkcs_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tkcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tkcs_pkg::rsp_type rsp_data
);

   localparam int AW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
   localparam int NW = $clog2(KEEP_DEPTH + 1);
   localparam int SW = tkcs_pkg::STAMP_BITS;

   typedef struct packed {
      logic [ID_BITS-1:0]    org;
      logic [ID_BITS-1:0]    dst;
      logic [COUNT_BITS-1:0] cnt;
      logic [SW-1:0]         arr;
   } entry_type;

   // record memory, one port written, one read, registered read data
   // not cleared; only entries below the record count are ever used
   entry_type mem [KEEP_DEPTH];
   entry_type rd_ff;
   logic      we;
   logic [AW-1:0] waddr, raddr;
   entry_type wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   tkcs_pkg::state_type state_ff, state_in;
   tkcs_pkg::req_type   req_ff, req_in;
   logic [NW-1:0] held_ff, held_in;
   logic [SW-1:0] stamp_ff, stamp_in;
   logic [AW-1:0] best_ff, best_in;
   entry_type     bestv_ff, bestv_in;
   logic [NW-1:0] idx_ff, idx_in;       // address issued this cycle for read
   logic          first_ff, first_in;   // next returned read is the first of the scan
   logic          pend_ff, pend_in;     // a read is in flight
   logic [AW-1:0] paddr_ff, paddr_in;   // address of the read in flight
   logic          rv_ff, rv_in;
   tkcs_pkg::rsp_type rsp_ff, rsp_in;

   logic full, take;
   logic better;
   assign full = (held_ff == NW'(KEEP_DEPTH));
   assign take = (req_ff.op == tkcs_pkg::OP_TAKE);

   // shared compare unit: greatest for take, least for insert, earliest among ties
   always_comb begin
      if (take) begin
         better = (rd_ff.cnt > bestv_ff.cnt) ||
                  (rd_ff.cnt == bestv_ff.cnt && rd_ff.arr < bestv_ff.arr);
      end else begin
         better = (rd_ff.cnt < bestv_ff.cnt) ||
                  (rd_ff.cnt == bestv_ff.cnt && rd_ff.arr < bestv_ff.arr);
      end
   end

   assign req_stall = (state_ff != tkcs_pkg::ST_IDLE) || rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tkcs_pkg::ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               if (req_data.op == tkcs_pkg::OP_INSERT) begin
                  state_in = (held_ff == NW'(KEEP_DEPTH)) ? tkcs_pkg::ST_SCAN
                                                          : tkcs_pkg::ST_IDLE;
               end else begin
                  state_in = (held_ff == '0) ? tkcs_pkg::ST_IDLE : tkcs_pkg::ST_SCAN;
               end
            end
         end
         tkcs_pkg::ST_SCAN: begin
            if (!pend_ff && idx_ff == held_ff) begin
               state_in = take ? tkcs_pkg::ST_LAST : tkcs_pkg::ST_REPLACE;
            end
         end
         tkcs_pkg::ST_LAST:    state_in = tkcs_pkg::ST_MOVE;
         tkcs_pkg::ST_MOVE:    state_in = tkcs_pkg::ST_DONE;
         tkcs_pkg::ST_REPLACE: state_in = tkcs_pkg::ST_IDLE;
         tkcs_pkg::ST_DONE:    state_in = tkcs_pkg::ST_IDLE;
         default:              state_in = tkcs_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in   = req_ff;
      held_in  = held_ff;
      stamp_in = stamp_ff;
      best_in  = best_ff;
      bestv_in = bestv_ff;
      idx_in   = idx_ff;
      first_in = first_ff;
      pend_in  = 1'b0;
      paddr_in = paddr_ff;
      rv_in    = rv_ff && rsp_stall;
      rsp_in   = rsp_ff;
      we       = 1'b0;
      waddr    = '0;
      wdata    = '0;
      raddr    = '0;
      case (state_ff)
         tkcs_pkg::ST_IDLE: begin
            if (req_valid && !rv_ff) begin
               req_in   = req_data;
               idx_in   = '0;
               first_in = 1'b1;
               if (req_data.op == tkcs_pkg::OP_INSERT) begin
                  stamp_in = stamp_ff + 1'b1;
                  if (!full) begin
                     we       = 1'b1;
                     waddr    = held_ff[AW-1:0];
                     wdata.org = req_data.origin_id[ID_BITS-1:0];
                     wdata.dst = req_data.dest_id[ID_BITS-1:0];
                     wdata.cnt = req_data.trip_count[COUNT_BITS-1:0];
                     wdata.arr = stamp_ff;
                     held_in  = held_ff + 1'b1;
                  end
               end else if (held_ff == '0) begin
                  rv_in  = 1'b1;
                  rsp_in = '0;
               end
            end
         end
         tkcs_pkg::ST_SCAN: begin
            // fold in the entry read last cycle
            if (pend_ff) begin
               if (first_ff || better) begin
                  best_in  = paddr_ff;
                  bestv_in = rd_ff;
               end
               first_in = 1'b0;
            end
            // issue next read
            if (idx_ff != held_ff) begin
               raddr    = idx_ff[AW-1:0];
               paddr_in = idx_ff[AW-1:0];
               pend_in  = 1'b1;
               idx_in   = idx_ff + 1'b1;
            end
         end
         tkcs_pkg::ST_LAST: begin
            raddr = NW'(held_ff - 1'b1) < NW'(KEEP_DEPTH) ?
                    AW'(held_ff - 1'b1) : '0;
            rv_in = 1'b0;
            rsp_in.valid_res     = 1'b1;
            rsp_in.out_origin_id = 16'(bestv_ff.org);
            rsp_in.out_dest_id   = 16'(bestv_ff.dst);
            rsp_in.out_count     = 32'(bestv_ff.cnt);
         end
         tkcs_pkg::ST_MOVE: begin
            we      = 1'b1;
            waddr   = best_ff;
            wdata   = rd_ff;
            held_in = held_ff - 1'b1;
         end
         tkcs_pkg::ST_REPLACE: begin
            if (req_ff.trip_count[COUNT_BITS-1:0] > bestv_ff.cnt) begin
               we        = 1'b1;
               waddr     = best_ff;
               wdata.org = req_ff.origin_id[ID_BITS-1:0];
               wdata.dst = req_ff.dest_id[ID_BITS-1:0];
               wdata.cnt = req_ff.trip_count[COUNT_BITS-1:0];
               wdata.arr = stamp_ff - 1'b1;
            end
         end
         tkcs_pkg::ST_DONE: begin
            rv_in = 1'b1;
         end
         default: begin
            rv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkcs_pkg::ST_IDLE;
         held_ff  <= '0;
         stamp_ff <= '0;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         stamp_ff <= stamp_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      best_ff  <= best_in;
      bestv_ff <= bestv_in;
      idx_ff   <= idx_in;
      first_ff <= first_in;
      paddr_ff <= paddr_in;
      rsp_ff   <= rsp_in;
   end

endmodule
